FILE: src/sbl_pkg.sv
package sbl_pkg;

  localparam int LOG2_STEPS = 16;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = CFG_IDX_W'(1);

  localparam logic [15:0] EXPONENT_RESET = 16'd4096;
  localparam logic [15:0] BASE_RESET     = 16'd65000;

  // how the suppressor result is formed for one item
  typedef enum logic [1:0] {
    RC_CALC,
    RC_ONE,
    RC_ZERO
  } rcase_t;

  // first half of the exp2 fraction polynomial: 43024 + 22512*f/2^16
  function automatic logic [15:0] exp2_mid(input logic [15:0] f);
    logic [31:0] pr;
    logic [31:0] sum;
    pr  = 32'd22512 * {16'b0, f};
    sum = 32'd43024 + {16'b0, pr[31:16]};
    return sum[15:0];
  endfunction

  // second half: 1.0 + f*mid/2^16, Q1.16
  function automatic logic [16:0] exp2_fin(input logic [15:0] f, input logic [15:0] mid);
    logic [31:0] pr;
    pr = {16'b0, f} * {16'b0, mid};
    return 17'h10000 + {1'b0, pr[31:16]};
  endfunction

endpackage

FILE: src/spectrum_bin_level_colormap_core.sv
// Spectrum bin level and color map.
// Input channel in_*: one transform bin per item (signed real and imaginary
// parts). Result channel out_*: the compressed level in Q0.16 and an RGB
// color running from black through blue and red to yellow.
// Config channel cfg_*: register 0 is the exponent (Q4.12), register 1 the
// suppressor base (Q0.16). cfg_ready is always high; write only while no
// item is in flight.
// One item enters every cycle while in_stall is low; the pipeline depth is set
// by the 16 squaring stages of the log2 units, the split 44x21 product and the
// two-stage exp2 polynomials.
// All stages advance together. When out_stall holds a valid result, in_stall
// rises and the whole pipeline holds; nothing is dropped or repeated.
// Synchronous reset (rst_n low) empties the pipeline and loads the register
// defaults: exponent 1.0, base 65000.
module spectrum_bin_level_colormap_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_bin_real,
  input  logic signed [31:0]           in_bin_imag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_level,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);
  import sbl_pkg::*;

  localparam int NSTG = 32;
  localparam int LAST = NSTG - 1;

  logic            en;
  logic [LAST:0]   vld_r;
  logic [15:0]     exp_r;
  logic [15:0]     base_r;

  assign en        = !vld_r[LAST] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[LAST];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= EXPONENT_RESET;
      base_r <= BASE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_EXPONENT) exp_r <= cfg_data;
      if (cfg_index == REG_BASE)     base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // stage 0: magnitudes
  logic [31:0] a_r, b_r;
  // stage 1: squares
  logic [63:0] aa_r, bb_r;
  // stage 2: power
  logic [63:0] p2_r;
  // stage 3: per-byte leading one
  logic [63:0] p3_r;
  logic [7:0]  nz3_r;
  logic [2:0]  pos3_r [8];
  // stage 4: leading one index
  logic [63:0] p4_r;
  logic [5:0]  k4_r;
  // stage 5: mantissas
  logic [30:0] m5_r, ms5_r;
  logic [5:0]  k5_r;
  logic [3:0]  ks5_r;
  logic        zero5_r;

  logic [7:0]  nz3_nxt;
  logic [2:0]  pos3_nxt [8];
  logic [5:0]  k4_nxt;
  logic [63:0] norm;
  logic [3:0]  ks_nxt;

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz3_nxt[g]  = |p2_r[8*g +: 8];
      pos3_nxt[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (p2_r[8*g + j]) pos3_nxt[g] = 3'(j);
      end
    end
    k4_nxt = '0;
    for (int g = 0; g < 8; g++) begin
      if (nz3_r[g]) k4_nxt = {3'(g), pos3_r[g]};
    end
    norm   = p4_r << (6'd63 - k4_r);
    ks_nxt = '0;
    for (int j = 0; j < 16; j++) begin
      if (base_r[j]) ks_nxt = 4'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= in_bin_real[31] ? 32'(~in_bin_real + 32'sd1) : 32'(in_bin_real);
      b_r     <= in_bin_imag[31] ? 32'(~in_bin_imag + 32'sd1) : 32'(in_bin_imag);
      aa_r    <= {32'b0, a_r} * {32'b0, a_r};
      bb_r    <= {32'b0, b_r} * {32'b0, b_r};
      p2_r    <= aa_r + bb_r;
      p3_r    <= p2_r;
      nz3_r   <= nz3_nxt;
      pos3_r  <= pos3_nxt;
      p4_r    <= p3_r;
      k4_r    <= k4_nxt;
      m5_r    <= norm[63:33];
      k5_r    <= k4_r;
      zero5_r <= (p4_r == 64'd0);
      ms5_r   <= {15'b0, base_r} << (5'd30 - {1'b0, ks_nxt});
      ks5_r   <= ks_nxt;
    end
  end

  // stages 6..21: fraction bits of both logarithms
  logic [15:0] frac_p, frac_s;

  sbl_log2 u_log2_pow (
    .clk      (clk),
    .en       (en),
    .mant_in  (m5_r),
    .frac_out (frac_p)
  );

  sbl_log2 u_log2_base (
    .clk      (clk),
    .en       (en),
    .mant_in  (ms5_r),
    .frac_out (frac_s)
  );

  logic [5:0] k_dl    [LOG2_STEPS];
  logic [3:0] ks_dl   [LOG2_STEPS];
  logic       zero_dl [LOG2_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      k_dl[0]    <= k5_r;
      ks_dl[0]   <= ks5_r;
      zero_dl[0] <= zero5_r;
      for (int i = 1; i < LOG2_STEPS; i++) begin
        k_dl[i]    <= k_dl[i-1];
        ks_dl[i]   <= ks_dl[i-1];
        zero_dl[i] <= zero_dl[i-1];
      end
    end
  end

  // stage 22: exponent times log2 power, and -log2 base
  logic [37:0] t22_r;
  logic [20:0] ls22_r;
  logic        zero22_r;
  // stage 23..24: exp2 of the fraction
  logic [9:0]  ti23_r, ti24_r;
  logic [15:0] tf23_r, mid23_r;
  logic [20:0] ls23_r, ls24_r, ls25_r;
  logic        zero23_r, zero24_r;
  logic [16:0] e24_r;
  // stage 25: compressed value
  logic [43:0] q25_r;
  rcase_t      rc25_r, rc26_r, rc27_r, rc28_r, rc29_r, rc30_unused_n;
  // stage 26..27: q times -log2 base
  logic [52:0] pl26_r;
  logic [32:0] ph26_r;
  logic [5:0]  wi27_r, wi28_r, wi29_r;
  logic [15:0] wf27_r, f28_r, mid28_r;
  logic        wf0_27_r, wf0_28_r, wf0_29_r;
  logic [16:0] e29_r;
  logic [16:0] r30_r;

  logic [43:0] q_nxt;
  logic        huge_nxt;
  rcase_t      rc_nxt;
  logic [63:0] w_nxt;
  logic [16:0] r_nxt;

  assign rc30_unused_n = rc29_r;

  always_comb begin
    huge_nxt = 1'b0;
    if (zero24_r) begin
      q_nxt = (exp_r == 16'd0) ? 44'h10000 : 44'd0;
    end else if (ti24_r >= 10'd28) begin
      q_nxt    = '0;
      huge_nxt = 1'b1;
    end else begin
      q_nxt = {27'b0, e24_r} << ti24_r[4:0];
    end
    if (q_nxt == 44'd0 && !huge_nxt) rc_nxt = RC_ONE;
    else if (huge_nxt || base_r == 16'd0) rc_nxt = RC_ZERO;
    else rc_nxt = RC_CALC;

    w_nxt = 64'(pl26_r) + (64'(ph26_r) << 32);

    case (rc30_unused_n)
      RC_ONE:  r_nxt = 17'h10000;
      RC_ZERO: r_nxt = '0;
      default: begin
        if (wf0_29_r) r_nxt = (wi29_r >= 6'd32) ? 17'd0 : (17'h10000 >> wi29_r);
        else r_nxt = (wi29_r >= 6'd31) ? 17'd0 : (e29_r >> (wi29_r + 6'd1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t22_r    <= {22'b0, exp_r} * {16'b0, k_dl[LOG2_STEPS-1], frac_p};
      ls22_r   <= 21'h100000 - {1'b0, ks_dl[LOG2_STEPS-1], frac_s};
      zero22_r <= zero_dl[LOG2_STEPS-1];

      ti23_r   <= t22_r[37:28];
      tf23_r   <= t22_r[27:12];
      mid23_r  <= exp2_mid(t22_r[27:12]);
      ls23_r   <= ls22_r;
      zero23_r <= zero22_r;

      e24_r    <= exp2_fin(tf23_r, mid23_r);
      ti24_r   <= ti23_r;
      ls24_r   <= ls23_r;
      zero24_r <= zero23_r;

      q25_r    <= q_nxt;
      rc25_r   <= rc_nxt;
      ls25_r   <= ls24_r;

      pl26_r   <= {21'b0, q25_r[31:0]} * {32'b0, ls25_r};
      ph26_r   <= {21'b0, q25_r[43:32]} * {12'b0, ls25_r};
      rc26_r   <= rc25_r;

      wi27_r   <= (|w_nxt[63:38]) ? 6'd63 : w_nxt[37:32];
      wf27_r   <= w_nxt[31:16];
      wf0_27_r <= (w_nxt[31:16] == 16'd0);
      rc27_r   <= rc26_r;

      f28_r    <= 16'(~wf27_r + 16'd1);
      mid28_r  <= exp2_mid(16'(~wf27_r + 16'd1));
      wi28_r   <= wi27_r;
      wf0_28_r <= wf0_27_r;
      rc28_r   <= rc27_r;

      e29_r    <= exp2_fin(f28_r, mid28_r);
      wi29_r   <= wi28_r;
      wf0_29_r <= wf0_28_r;
      rc29_r   <= rc28_r;

      r30_r    <= r_nxt;
    end
  end

  // stage 31: level and color
  logic [16:0] lvl_full;
  logic [15:0] lvl;
  logic [23:0] rx, gx;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;

  always_comb begin
    lvl_full = 17'h10000 - r30_r;
    lvl      = (r30_r == 17'd0) ? 16'hFFFF : lvl_full[15:0];
    rx       = 24'(lvl - 16'd16384) * 24'd255;
    gx       = 24'(lvl - 16'd32768) * 24'd255;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (lvl <= 16'd16384) begin
      blue_nxt = 8'(lvl >> 7);
    end else if (lvl <= 16'd32768) begin
      red_nxt  = rx[21:14];
      blue_nxt = 8'((16'd32768 - lvl) >> 7);
    end else begin
      red_nxt   = 8'd255;
      green_nxt = gx[22:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_level <= lvl;
      out_red   <= red_nxt;
      out_green <= green_nxt;
      out_blue  <= blue_nxt;
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pipeline not empty after reset");
  a_blue_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_blue <= 8'd128)
    else $error("blue above 128");
  a_low_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level <= 16'd16384 |-> out_red == 8'd0 && out_green == 8'd0)
    else $error("low level band has red or green");
  a_high_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level > 16'd32768 |-> out_red == 8'd255 && out_blue == 8'd0)
    else $error("high level band color wrong");
`endif

endmodule

FILE: src/sbl_log2.sv
module sbl_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] mant_in,
  output logic [15:0] frac_out
);
  import sbl_pkg::*;

  logic [30:0] m_r [LOG2_STEPS];
  logic [15:0] f_r [LOG2_STEPS];

  // one fraction bit per stage: square the Q1.30 mantissa and renormalize
  for (genvar i = 0; i < LOG2_STEPS; i++) begin : g_step
    logic [30:0] m_prev;
    logic [15:0] f_prev;
    logic [61:0] sq;
    logic [31:0] sh;

    if (i == 0) begin : g_first
      assign m_prev = mant_in;
      assign f_prev = '0;
    end else begin : g_next
      assign m_prev = m_r[i-1];
      assign f_prev = f_r[i-1];
    end

    assign sq = {31'b0, m_prev} * {31'b0, m_prev};
    assign sh = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i] <= sh[31] ? sh[31:1] : sh[30:0];
        f_r[i] <= {f_prev[14:0], sh[31]};
      end
    end
  end

  assign frac_out = f_r[LOG2_STEPS-1];

endmodule
